>>> hdl/rclfr_pkg.sv
// Shared types, constants and the CRC8 byte update for the link frame receiver.
// Used by rclfr_parser and rc_link_frame_receiver_crc8; depends on nothing else.
`timescale 1ns / 1ps

package rclfr_pkg;

    // Default counter width and field widths
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int BYTE_W          = 8;
    localparam int POS_W           = 7;
    localparam int STATUS_W        = 3;
    localparam int COUNT_OUT_W     = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 8;
    localparam int IN_TDATA_W      = 8;
    // data_byte + byte_index + good_count + bad_count = 79, padded to 80
    localparam int OUT_TDATA_W     = 80;

    // Shortest accepted length byte
    localparam logic [BYTE_W-1:0] MIN_LEN = 8'd2;

    // Register reset values
    localparam logic [7:0] CRC_POLY_RST = 8'hD5;
    localparam logic [6:0] MAX_LEN_RST  = 7'd64;
    localparam logic [7:0] SYNC_A_RST   = 8'hC8;
    localparam logic [7:0] SYNC_B_RST   = 8'hEA;
    localparam logic [7:0] SYNC_C_RST   = 8'hEE;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CRC_POLY = 3'd0,
        REG_MAX_LEN  = 3'd1,
        REG_SYNC_A   = 3'd2,
        REG_SYNC_B   = 3'd3,
        REG_SYNC_C   = 3'd4
    } reg_index_t;

    // Per-byte status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_NO_SYNC  = 3'd0,
        STS_START    = 3'd1,
        STS_TAKEN    = 3'd2,
        STS_GOOD     = 3'd3,
        STS_BAD_CRC  = 3'd4,
        STS_LEN_REJ  = 3'd5,
        STS_OVERFLOW = 3'd6
    } status_t;

    // Live configuration
    typedef struct packed {
        logic [7:0] crc_poly;
        logic [6:0] max_frame_len;
        logic [7:0] sync_a;
        logic [7:0] sync_b;
        logic [7:0] sync_c;
    } cfg_t;

    // One result item
    typedef struct packed {
        status_t                  status;
        logic [BYTE_W-1:0]        data_byte;
        logic [POS_W-1:0]         byte_index;
        logic [COUNT_OUT_W-1:0]   good_count;
        logic [COUNT_OUT_W-1:0]   bad_count;
    } result_t;

    // CRC8 over one byte, MSB first, top polynomial bit implicit
    function automatic logic [7:0] crc8_byte(
        input logic [7:0] crc,
        input logic [7:0] data,
        input logic [7:0] poly
    );
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> hdl/rclfr_parser.sv
// Frame parser: sync search, length check, running CRC8 and frame counters.
// Depends on rclfr_pkg; instantiated by rc_link_frame_receiver_crc8.
`timescale 1ns / 1ps

module rclfr_parser #(
    parameter int COUNT_WIDTH = rclfr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rclfr_pkg::cfg_t                 cfg,
    input  logic                            take,
    input  logic [rclfr_pkg::BYTE_W-1:0]    rx_byte,
    output rclfr_pkg::result_t              result
);

    logic                              in_frame_reg, in_frame_next;
    logic [rclfr_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [rclfr_pkg::POS_W-1:0]       len_reg, len_next;
    logic [7:0]                        crc_reg, crc_next;
    logic [COUNT_WIDTH-1:0]            good_reg, good_next;
    logic [COUNT_WIDTH-1:0]            bad_reg, bad_next;

    logic                              is_sync;
    logic [7:0]                        pos_ext;
    logic [7:0]                        max_ext;
    logic [7:0]                        len_ext;
    rclfr_pkg::status_t                status;
    logic [rclfr_pkg::POS_W-1:0]       index;

    assign is_sync = (rx_byte == cfg.sync_a) || (rx_byte == cfg.sync_b)
                     || (rx_byte == cfg.sync_c);
    assign pos_ext = {1'b0, pos_reg};
    assign max_ext = {1'b0, cfg.max_frame_len};
    assign len_ext = {1'b0, len_reg};

    // Decide status and next state for the byte on the input
    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        crc_next      = crc_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        index         = pos_reg;
        status        = rclfr_pkg::STS_TAKEN;

        if (!in_frame_reg)
        begin
            index = '0;
            if (is_sync)
            begin
                in_frame_next = 1'b1;
                pos_next      = 7'd1;
                len_next      = '0;
                crc_next      = '0;
                status        = rclfr_pkg::STS_START;
            end
            else
            begin
                status = rclfr_pkg::STS_NO_SYNC;
            end
        end
        else if (pos_ext > max_ext + 8'd1)
        begin
            // Limit lowered mid-frame: abandon without counting
            status        = rclfr_pkg::STS_OVERFLOW;
            in_frame_next = 1'b0;
            pos_next      = '0;
            len_next      = '0;
            crc_next      = '0;
        end
        else if (pos_reg == 7'd1)
        begin
            if (rx_byte >= rclfr_pkg::MIN_LEN && rx_byte <= max_ext)
            begin
                len_next = rx_byte[rclfr_pkg::POS_W-1:0];
                pos_next = 7'd2;
                status   = rclfr_pkg::STS_TAKEN;
            end
            else
            begin
                status        = rclfr_pkg::STS_LEN_REJ;
                in_frame_next = 1'b0;
                pos_next      = '0;
                len_next      = '0;
                crc_next      = '0;
            end
        end
        else if (pos_ext >= len_ext + 8'd1)
        begin
            // CRC byte: check and bump the matching counter
            if (rx_byte == crc_reg)
            begin
                good_next = good_reg + COUNT_WIDTH'(1);
                status    = rclfr_pkg::STS_GOOD;
            end
            else
            begin
                bad_next = bad_reg + COUNT_WIDTH'(1);
                status   = rclfr_pkg::STS_BAD_CRC;
            end
            in_frame_next = 1'b0;
            pos_next      = '0;
            len_next      = '0;
            crc_next      = '0;
        end
        else
        begin
            crc_next = rclfr_pkg::crc8_byte(crc_reg, rx_byte, cfg.crc_poly);
            pos_next = pos_reg + 7'd1;
            status   = rclfr_pkg::STS_TAKEN;
        end
    end

    // Result of this byte, counters as they stand after it
    always_comb
    begin
        result.status     = status;
        result.data_byte  = rx_byte;
        result.byte_index = index;
        result.good_count = rclfr_pkg::COUNT_OUT_W'(good_next);
        result.bad_count  = rclfr_pkg::COUNT_OUT_W'(bad_next);
    end

    // Advance frame state on each taken byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            len_reg      <= '0;
            crc_reg      <= '0;
            good_reg     <= '0;
            bad_reg      <= '0;
        end
        else if (take)
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            crc_reg      <= crc_next;
            good_reg     <= good_next;
            bad_reg      <= bad_next;
        end
    end

endmodule

>>> hdl/rc_link_frame_receiver_crc8.sv
// Top level of the link frame receiver: configuration registers, parser, output skid.
// Depends on rclfr_pkg and rclfr_parser.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_tvalid / s_tready       s_tdata: rx_byte
//  m_axis    out        m_tvalid / m_tready       m_tuser: status; m_tdata: data, index, counts
//  cfg       in         cfg_wen (no handshake)    cfg_index, cfg_data
//
//  Each accepted byte yields one result transfer; the parser and CRC8 update are
//  combinational between the frame state and the result register, so one byte
//  per clock is sustained while the output is not stalled.
//  A two-entry output (result register plus skid) keeps s_tready high while a
//  result waits; s_tready drops only when both are full.
//  Reset clears the frame state, counters and registers to their defaults.

module rc_link_frame_receiver_crc8 #(
    parameter int COUNT_WIDTH = rclfr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rclfr_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rclfr_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [7:0] data_byte, [14:8] byte_index,
                                                            // [46:15] good_count,
                                                            // [78:47] bad_count, [79] zero
    output logic [rclfr_pkg::STATUS_W-1:0]       m_tuser,   // [2:0] status
    // Configuration writes
    input  logic                                 cfg_wen,
    input  logic [rclfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rclfr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rclfr_pkg::cfg_t      cfg_reg;
    rclfr_pkg::result_t   result;
    rclfr_pkg::result_t   out_reg;
    rclfr_pkg::result_t   skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic                 take;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_poly      <= rclfr_pkg::CRC_POLY_RST;
            cfg_reg.max_frame_len <= rclfr_pkg::MAX_LEN_RST;
            cfg_reg.sync_a        <= rclfr_pkg::SYNC_A_RST;
            cfg_reg.sync_b        <= rclfr_pkg::SYNC_B_RST;
            cfg_reg.sync_c        <= rclfr_pkg::SYNC_C_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                rclfr_pkg::REG_CRC_POLY: cfg_reg.crc_poly      <= cfg_data;
                rclfr_pkg::REG_MAX_LEN:  cfg_reg.max_frame_len <= cfg_data[6:0];
                rclfr_pkg::REG_SYNC_A:   cfg_reg.sync_a        <= cfg_data;
                rclfr_pkg::REG_SYNC_B:   cfg_reg.sync_b        <= cfg_data;
                rclfr_pkg::REG_SYNC_C:   cfg_reg.sync_c        <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign take     = s_tvalid && s_tready;

    rclfr_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .take    (take),
        .rx_byte (s_tdata[rclfr_pkg::BYTE_W-1:0]),
        .result  (result)
    );

    // Valid flags for the result register and the skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (m_tready)
                    skid_valid_reg <= 1'b0;
            end
            else if (take)
            begin
                if (!out_valid_reg || m_tready)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result register from the skid entry first, else from the parser
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                out_reg <= skid_reg;
        end
        else if (take)
        begin
            if (!out_valid_reg || m_tready)
                out_reg <= result;
            else
                skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.bad_count, out_reg.good_count,
                       out_reg.byte_index, out_reg.data_byte};

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for rc_link_frame_receiver_crc8: drives received bytes, predicts each
// echo and compares it. Depends on rclfr_pkg and the receiver RTL only.
`timescale 1ns / 1ps

module tb_top;

    import rclfr_pkg::*;

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Tracks the receiver's frame state and holds the echoes still to come
    class frame_tracker;
        logic [7:0] poly;
        logic [6:0] max_len;
        logic [7:0] sync_a;
        logic [7:0] sync_b;
        logic [7:0] sync_c;
        bit         frame_open;
        logic [6:0] pos;
        logic [6:0] flen;
        logic [7:0] crc;
        logic [31:0] good_n;
        logic [31:0] bad_n;
        result_t    pending_echoes[$];
        int         errors;

        function new();
            poly       = CRC_POLY_RST;
            max_len    = MAX_LEN_RST;
            sync_a     = SYNC_A_RST;
            sync_b     = SYNC_B_RST;
            sync_c     = SYNC_C_RST;
            good_n     = '0;
            bad_n      = '0;
            errors     = 0;
            close_frame();
        endfunction

        function void close_frame();
            frame_open = 1'b0;
            pos        = '0;
            flen       = '0;
            crc        = '0;
        endfunction

        // Mirror one register write
        function void set_reg(reg_index_t idx, logic [7:0] v);
            case (idx)
                REG_CRC_POLY: poly    = v;
                REG_MAX_LEN:  max_len = v[6:0];
                REG_SYNC_A:   sync_a  = v;
                REG_SYNC_B:   sync_b  = v;
                REG_SYNC_C:   sync_c  = v;
                default: ;
            endcase
        endfunction

        // CRC8 over one byte, MSB first, top polynomial bit implicit
        function logic [7:0] crc_step(logic [7:0] acc, logic [7:0] b);
            logic [7:0] v;
            v = acc ^ b;
            for (int i = 0; i < 8; i++)
                v = (v << 1) ^ (v[7] ? poly : 8'h00);
            return v;
        endfunction

        function int pending();
            return pending_echoes.size();
        endfunction

        // Advance the frame state by one transferred byte and queue its echo
        function void predict_echo(logic [7:0] b);
            result_t r;
            r.data_byte  = b;
            r.byte_index = '0;
            if (!frame_open)
            begin
                if (b == sync_a || b == sync_b || b == sync_c)
                begin
                    frame_open = 1'b1;
                    pos        = 7'd1;
                    flen       = '0;
                    crc        = '0;
                    r.status   = STS_START;
                end
                else
                    r.status = STS_NO_SYNC;
            end
            else if (int'(pos) > int'(max_len) + 1)
            begin
                // limit lowered during the frame: drop it
                r.byte_index = pos;
                r.status     = STS_OVERFLOW;
                close_frame();
            end
            else if (pos == 7'd1)
            begin
                r.byte_index = 7'd1;
                if (b >= MIN_LEN && b <= {1'b0, max_len})
                begin
                    flen     = b[6:0];
                    pos      = 7'd2;
                    r.status = STS_TAKEN;
                end
                else
                begin
                    r.status = STS_LEN_REJ;
                    close_frame();
                end
            end
            else
            begin
                r.byte_index = pos;
                if (int'(pos) >= int'(flen) + 1)
                begin
                    if (b == crc)
                    begin
                        good_n   = good_n + 1;
                        r.status = STS_GOOD;
                    end
                    else
                    begin
                        bad_n    = bad_n + 1;
                        r.status = STS_BAD_CRC;
                    end
                    close_frame();
                end
                else
                begin
                    crc      = crc_step(crc, b);
                    pos      = pos + 7'd1;
                    r.status = STS_TAKEN;
                end
            end
            r.good_count = good_n;
            r.bad_count  = bad_n;
            pending_echoes.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] e, logic [31:0] a);
            if (a !== e)
            begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        // Compare one result transfer with the oldest queued echo
        function void compare_echo(logic [STATUS_W-1:0] tuser, logic [OUT_TDATA_W-1:0] tdata);
            result_t exp_r;
            if (pending_echoes.size() == 0)
            begin
                $error("result with no byte outstanding: status %0d, data_byte %0d",
                       tuser, tdata[7:0]);
                errors++;
                return;
            end
            exp_r = pending_echoes.pop_front();
            check_field("status", exp_r.status, tuser);
            check_field("data_byte", exp_r.data_byte, tdata[7:0]);
            check_field("byte_index", exp_r.byte_index, tdata[14:8]);
            check_field("good_count", exp_r.good_count, tdata[46:15]);
            check_field("bad_count", exp_r.bad_count, tdata[78:47]);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]      m_tuser;
    logic                     cfg_wen;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    frame_tracker tracker = new();

    int  burst_left  = 0;
    bit  gaps_on     = 1'b1;
    int  sent_items  = 0;
    int  noise_items = 0;
    int  quiet_cycles = 0;
    int  stall_mode  = 0;
    int  stall_left  = 0;
    int  stall_tick  = 0;

    rc_link_frame_receiver_crc8 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver back-pressure: switch between randomly chosen stall patterns
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (stall_tick % 4 == 0);
            default: m_tready <= (stall_tick % 8 < 3);
        endcase
    end

    // Note transferred bytes, then check transferred results, on the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.predict_echo(s_tdata);
            if (m_tvalid && m_tready)
                tracker.compare_echo(m_tuser, m_tdata);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one byte and hold it until the transfer; idle between bursts
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
    endtask

    // Stop offering and wait for every outstanding echo
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] v);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        tracker.set_reg(idx, v);
    endtask

    function automatic logic [7:0] pick_sync();
        case ($urandom_range(0, 2))
            0: return tracker.sync_a;
            1: return tracker.sync_b;
            default: return tracker.sync_c;
        endcase
    endfunction

    function automatic logic [7:0] bad_length();
        case ($urandom_range(0, 2))
            0: return 8'd0;
            1: return 8'd1;
            default: return $urandom_range(int'(tracker.max_len) + 1, 255);
        endcase
    endfunction

    // Sync, length, random type and payload, then the CRC byte (optionally wrong).
    // A cut of zero or more stops after that many payload bytes and leaves the frame open.
    task automatic send_frame(input int len, input bit corrupt, input int cut);
        logic [7:0] acc;
        logic [7:0] b;
        acc = 8'h00;
        send_byte(pick_sync());
        send_byte(len[7:0]);
        for (int k = 0; k < len - 1; k++)
        begin
            if (cut >= 0 && k >= cut)
                return;
            b   = $urandom_range(0, 255);
            acc = tracker.crc_step(acc, b);
            send_byte(b);
        end
        send_byte(corrupt ? acc ^ 8'($urandom_range(1, 255)) : acc);
    endtask

    // One random sequence: mostly whole frames, some noise and broken frames
    task automatic send_sequence();
        int kind;
        int n;
        int len;
        int hi;
        kind = $urandom_range(0, 99);
        hi   = (tracker.max_len < 12) ? int'(tracker.max_len) : 12;
        len  = ($urandom_range(0, 7) == 0) ? int'(tracker.max_len) : $urandom_range(2, hi);
        if (kind < 70)
            send_frame(len, $urandom_range(0, 4) == 0, -1);
        else if (kind < 80)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte($urandom_range(0, 255));
            noise_items += n;
        end
        else if (kind < 90)
        begin
            send_byte(pick_sync());
            send_byte(bad_length());
        end
        else
            send_frame(len, 1'b0, $urandom_range(0, len - 2));
    endtask

    // New register set for a phase; the first two take the extremes
    task automatic load_settings(input int phase);
        logic [7:0] poly_v;
        logic [6:0] max_v;
        logic [7:0] sa;
        logic [7:0] sbv;
        logic [7:0] sc;
        poly_v = $urandom_range(0, 255);
        case ($urandom_range(0, 3))
            0: max_v = 7'd4;
            1: max_v = 7'd64;
            default: max_v = $urandom_range(4, 64);
        endcase
        sa  = $urandom_range(0, 255);
        sbv = $urandom_range(0, 255);
        sc  = $urandom_range(0, 255);
        if (phase == 0)
        begin
            poly_v = 8'h00;
            max_v  = 7'd4;
            sa     = 8'h00;
            sbv    = 8'hFF;
            sc     = 8'h00;
        end
        else if (phase == 1)
        begin
            poly_v = 8'hFF;
            max_v  = 7'd64;
            sa     = 8'hFF;
            sbv    = 8'h80;
            sc     = 8'h7F;
        end
        write_reg(REG_CRC_POLY, poly_v);
        write_reg(REG_MAX_LEN, {1'b0, max_v});
        write_reg(REG_SYNC_A, sa);
        write_reg(REG_SYNC_B, sbv);
        write_reg(REG_SYNC_C, sc);
        cfg_wen <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] c;
        int start;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wen   <= 1'b0;
        cfg_index <= REG_CRC_POLY;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Shortest good frame, zero type byte, first sync value
        send_byte(SYNC_A_RST);
        send_byte(MIN_LEN);
        send_byte(8'h00);
        send_byte(tracker.crc_step(8'h00, 8'h00));

        // Second sync value, all-ones byte and sync values inside the frame, wrong CRC
        c = tracker.crc_step(8'h00, 8'hFF);
        c = tracker.crc_step(c, SYNC_A_RST);
        c = tracker.crc_step(c, SYNC_C_RST);
        send_byte(SYNC_B_RST);
        send_byte(8'd4);
        send_byte(8'hFF);
        send_byte(SYNC_A_RST);
        send_byte(SYNC_C_RST);
        send_byte(~c);

        // Non-sync byte while idle
        send_byte(8'hFF);

        // Rejected lengths: below the minimum and one above the maximum
        send_byte(SYNC_C_RST);
        send_byte(8'd1);
        send_byte(SYNC_A_RST);
        send_byte(8'd65);

        // Open a long frame, lower the limit under its position, then overflow
        send_byte(SYNC_A_RST);
        send_byte(8'd64);
        repeat (4) send_byte($urandom_range(0, 255));
        drain();
        write_reg(REG_MAX_LEN, 8'd4);
        cfg_wen <= 1'b0;
        send_byte(8'h5A);

        // Length equal to the limit
        send_frame(4, 1'b0, -1);

        // Random phases, each under its own register set
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            load_settings(phase);
            gaps_on = ($urandom_range(0, 3) != 0);
            start   = sent_items - noise_items;
            while (sent_items - noise_items - start < ITEMS_PER_PHASE)
                send_sequence();
            // leave a frame open so a lower limit in the next phase can overflow it
            if ($urandom_range(0, 1) == 1)
                send_frame(tracker.max_len, 1'b0, $urandom_range(2, int'(tracker.max_len) - 2));
        end

        drain();
        repeat (4) @(posedge clk);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
